>>> rtl/core/lnag_pkg.sv
// Shared types, widths and codes of the lattice neighbor address generator.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package lnag_pkg;

  localparam int NUM_DIRS  = 4;
  localparam int DIR_W     = 2;
  localparam int COORD_W   = 4;
  localparam int EXT_W     = 5;
  localparam int MAX_EXTENT = 16;
  localparam int MASK_W    = NUM_DIRS;
  localparam int SITE_W    = 16;
  localparam int IDX_W     = 17;
  localparam int SLOT_W    = 12;
  localparam int STRIDE_W  = 13;
  localparam int DELTA_W   = 6;
  localparam int PROD_W    = DELTA_W + STRIDE_W + 1;
  localparam int CNT_DEPTH = 16;
  localparam int CNT_IDX_W = 4;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = QPTR_W + 1;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;

  localparam logic [EXT_W-1:0] EXT_RESET = EXT_W'(4);

  typedef enum logic [2:0] {
    REG_EXTENT_X   = 3'd0,
    REG_EXTENT_Y   = 3'd1,
    REG_EXTENT_Z   = 3'd2,
    REG_EXTENT_T   = 3'd3,
    REG_LOCAL_COMM = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    BUF_FWD_FIELD = 2'd0,
    BUF_BWD_FIELD = 2'd1,
    BUF_FWD_SEND  = 2'd2,
    BUF_BWD_SEND  = 2'd3
  } buf_e;

  typedef struct packed {
    logic [NUM_DIRS-1:0][EXT_W-1:0] extent;
    logic [MASK_W-1:0]              local_mask;
  } cfg_t;

  // Per-direction classification: target buffer and coordinate step.
  typedef struct packed {
    buf_e               tbuf;
    logic [DELTA_W-1:0] delta;
  } dir_info_t;

  typedef struct packed {
    logic                              parity;
    logic                              sense;
    logic [SITE_W-1:0]                 tab_site;
    logic [NUM_DIRS-1:0][STRIDE_W-1:0] stride;
    dir_info_t [NUM_DIRS-1:0]          dirs;
  } site_entry_t;

  typedef struct packed {
    logic [DIR_W-1:0]  direction;
    logic              site_parity;
    logic              table_sense;
    logic [IDX_W-1:0]  table_index;
    buf_e              target_buffer;
    logic [IDX_W-1:0]  element_offset;
    logic              face_write;
    logic              face_sense;
    logic [SLOT_W-1:0] face_slot;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/lnag_front.sv
// Front end: accepts a site, builds its lexicographic index and the axis
// strides, and classifies all four neighbors.
// Depends on lnag_pkg.
`default_nettype none

module lnag_front (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  lnag_pkg::cfg_t                                  cfg_i,
  input  logic                                            push_i,
  input  logic [lnag_pkg::NUM_DIRS-1:0][lnag_pkg::COORD_W-1:0] coord_i,
  input  logic                                            sense_i,
  output logic                                            full_o,
  output logic                                            q_wr_o,
  output lnag_pkg::site_entry_t                           q_wdata_o,
  input  logic                                            q_full_i
);
  import lnag_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_Z,
    ST_MUL_Y,
    ST_PUSH
  } state_e;

  state_e                             state_q;
  logic [NUM_DIRS-1:0][COORD_W-1:0]   coord_q;
  logic                               sense_q;
  logic [SITE_W-1:0]                  site_q;
  logic [STRIDE_W-1:0]                st2_q;
  logic [STRIDE_W-1:0]                st3_q;

  logic [SITE_W-1:0]                  site_fin;
  dir_info_t [NUM_DIRS-1:0]           dirs;

  assign full_o = (state_q != ST_IDLE);
  assign q_wr_o = (state_q == ST_PUSH) && !q_full_i;

  // Horner steps over t, z, y; the x step feeds the queue write directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      coord_q <= '0;
      sense_q <= 1'b0;
      site_q  <= '0;
      st2_q   <= '0;
      st3_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (push_i) begin
            coord_q <= coord_i;
            sense_q <= sense_i;
            site_q  <= SITE_W'(coord_i[3]);
            state_q <= ST_MUL_Z;
          end
        end
        ST_MUL_Z: begin
          site_q  <= SITE_W'(coord_q[2]) + SITE_W'(cfg_i.extent[2]) * site_q;
          st2_q   <= STRIDE_W'(cfg_i.extent[0]) * STRIDE_W'(cfg_i.extent[1]);
          state_q <= ST_MUL_Y;
        end
        ST_MUL_Y: begin
          site_q  <= SITE_W'(coord_q[1]) + SITE_W'(cfg_i.extent[1]) * site_q;
          st3_q   <= st2_q * STRIDE_W'(cfg_i.extent[2]);
          state_q <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!q_full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign site_fin = SITE_W'(coord_q[0]) + SITE_W'(cfg_i.extent[0]) * site_q;

  always_comb begin
    logic [COORD_W-1:0] c;
    logic [EXT_W-1:0]   e;
    logic [EXT_W-1:0]   sc;
    logic               at_minus;
    logic               at_plus;
    for (int mu = 0; mu < NUM_DIRS; mu++) begin
      c        = coord_q[mu];
      e        = cfg_i.extent[mu];
      at_minus = sense_q && (c == '0);
      sc       = sense_q ? EXT_W'(c) - 1'b1 : EXT_W'(c) + 1'b1;
      at_plus  = !at_minus && (sc >= e);
      dirs[mu].tbuf  = sense_q ? BUF_BWD_FIELD : BUF_FWD_FIELD;
      dirs[mu].delta = sense_q ? '1 : DELTA_W'(1);
      if (at_minus || at_plus) begin
        if (cfg_i.local_mask[mu]) begin
          if (at_minus) begin
            // wrap to the far face; an empty axis wraps to zero
            dirs[mu].tbuf  = BUF_BWD_FIELD;
            dirs[mu].delta = (e == '0) ? '0 : DELTA_W'(e) - 1'b1;
          end else begin
            dirs[mu].tbuf  = BUF_FWD_FIELD;
            dirs[mu].delta = DELTA_W'(0) - DELTA_W'(c);
          end
        end else begin
          dirs[mu].tbuf  = at_minus ? BUF_BWD_SEND : BUF_FWD_SEND;
          dirs[mu].delta = '0;
        end
      end
    end
  end

  always_comb begin
    q_wdata_o.parity    = ^{coord_q[0][0], coord_q[1][0], coord_q[2][0], coord_q[3][0]};
    q_wdata_o.sense     = sense_q;
    q_wdata_o.tab_site  = site_fin;
    q_wdata_o.stride[0] = STRIDE_W'(1);
    q_wdata_o.stride[1] = STRIDE_W'(cfg_i.extent[0]);
    q_wdata_o.stride[2] = st2_q;
    q_wdata_o.stride[3] = st3_q;
    q_wdata_o.dirs      = dirs;
  end

endmodule

`default_nettype wire

>>> rtl/core/lnag_fifo.sv
// Short queue of classified sites between the front and back ends.
// Depends on lnag_pkg.
`default_nettype none

module lnag_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_i,
  input  lnag_pkg::site_entry_t wdata_i,
  output logic                  full_o,
  input  logic                  rd_i,
  output lnag_pkg::site_entry_t rdata_o,
  output logic                  empty_o
);
  import lnag_pkg::*;

  site_entry_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wptr_q;
  logic [QPTR_W-1:0]   rptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                do_wr;
  logic                do_rd;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lnag_back.sv
// Back end: walks the four directions of the head site, forms neighbor
// offsets, takes send slots from the counter file and holds the result.
// Depends on lnag_pkg.
`default_nettype none

module lnag_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  lnag_pkg::site_entry_t q_rdata_i,
  output logic                  q_rd_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output lnag_pkg::result_t     res_o
);
  import lnag_pkg::*;

  logic [DIR_W-1:0]         dir_q;
  logic                     out_valid_q;
  result_t                  res_q;
  result_t                  res_d;
  logic [SLOT_W-1:0]        cnt_q [CNT_DEPTH];

  logic                     advance;
  dir_info_t                dinfo;
  logic signed [PROD_W-1:0] prod;
  logic [SITE_W-1:0]        nsite;
  logic                     send;
  logic [CNT_IDX_W-1:0]     cnt_idx;
  logic [SLOT_W-1:0]        slot;

  assign empty_o = !out_valid_q;
  assign res_o   = res_q;
  assign advance = !q_empty_i && (!out_valid_q || pop_i);
  assign q_rd_o  = advance && (dir_q == DIR_W'(NUM_DIRS - 1));

  assign dinfo   = q_rdata_i.dirs[dir_q];
  assign prod    = $signed(dinfo.delta) * $signed({1'b0, q_rdata_i.stride[dir_q]});
  // the true neighbor index fits the site width, so modular sums are exact
  assign nsite   = q_rdata_i.tab_site + prod[SITE_W-1:0];
  assign send    = dinfo.tbuf[1];
  assign cnt_idx = {q_rdata_i.parity, dinfo.tbuf[0], dir_q};
  assign slot    = cnt_q[cnt_idx];

  always_comb begin
    res_d.direction      = dir_q;
    res_d.site_parity    = q_rdata_i.parity;
    res_d.table_sense    = q_rdata_i.sense;
    res_d.table_index    = {q_rdata_i.tab_site[SITE_W-1:1], dir_q};
    res_d.target_buffer  = dinfo.tbuf;
    res_d.element_offset = send ? IDX_W'(slot) : {nsite[SITE_W-1:1], dir_q};
    res_d.face_write     = send;
    res_d.face_sense     = send && !q_rdata_i.sense;
    res_d.face_slot      = send ? slot : '0;
    res_d.last           = (dir_q == DIR_W'(NUM_DIRS - 1));
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CNT_DEPTH; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        dir_q       <= dir_q + 1'b1;
        if (send) begin
          cnt_q[cnt_idx] <= slot + 1'b1;
        end
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lattice_neighbor_address_generator_top.sv
// Lattice neighbor address generator: one site in, four direction results out.
// Flow: a site passes the front-end states ST_MUL_Z, ST_MUL_Y and ST_PUSH, the
// queue and the result register; results follow one per cycle while pop keeps up.
// The front end holds full and takes no new site until the last one is in the queue.
// Reset: extents return to 4, local comms mask to 0, all send counters to 0.
// Depends on lnag_pkg, lnag_front, lnag_fifo and lnag_back.
`default_nettype none

module lattice_neighbor_address_generator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lnag_pkg::APB_AW-1:0]     paddr,
  input  logic [lnag_pkg::APB_DW-1:0]     pwdata,
  output logic [lnag_pkg::APB_DW-1:0]     prdata,
  output logic                            pready,
  // site requests
  input  logic                            push,
  output logic                            full,
  input  logic [lnag_pkg::COORD_W-1:0]    coord_x_i,
  input  logic [lnag_pkg::COORD_W-1:0]    coord_y_i,
  input  logic [lnag_pkg::COORD_W-1:0]    coord_z_i,
  input  logic [lnag_pkg::COORD_W-1:0]    coord_t_i,
  input  logic                            shift_sense_i,
  // results
  output logic                            empty,
  input  logic                            pop,
  output logic [lnag_pkg::DIR_W-1:0]      direction_o,
  output logic                            site_parity_o,
  output logic                            table_sense_o,
  output logic [lnag_pkg::IDX_W-1:0]      table_index_o,
  output logic [1:0]                      target_buffer_o,
  output logic [lnag_pkg::IDX_W-1:0]      element_offset_o,
  output logic                            face_write_o,
  output logic                            face_sense_o,
  output logic [lnag_pkg::SLOT_W-1:0]     face_slot_o,
  output logic                            last_o
);
  import lnag_pkg::*;

  cfg_t                             cfg_q;
  logic                             cfg_wr;
  reg_idx_e                         reg_idx;
  logic [EXT_W-1:0]                 ext_wr;
  logic [NUM_DIRS-1:0][COORD_W-1:0] coord;
  logic                             q_wr;
  logic                             q_full;
  logic                             q_rd;
  logic                             q_empty;
  site_entry_t                      q_wdata;
  site_entry_t                      q_rdata;
  result_t                          res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[APB_AW-1:2]);
  // clamp extents to the largest supported lattice
  assign ext_wr  = (pwdata[EXT_W-1:0] > EXT_W'(MAX_EXTENT)) ? EXT_W'(MAX_EXTENT)
                                                            : pwdata[EXT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.extent     <= {NUM_DIRS{EXT_RESET}};
      cfg_q.local_mask <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_EXTENT_X:   cfg_q.extent[0]  <= ext_wr;
        REG_EXTENT_Y:   cfg_q.extent[1]  <= ext_wr;
        REG_EXTENT_Z:   cfg_q.extent[2]  <= ext_wr;
        REG_EXTENT_T:   cfg_q.extent[3]  <= ext_wr;
        REG_LOCAL_COMM: cfg_q.local_mask <= pwdata[MASK_W-1:0];
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_EXTENT_X:   prdata = APB_DW'(cfg_q.extent[0]);
      REG_EXTENT_Y:   prdata = APB_DW'(cfg_q.extent[1]);
      REG_EXTENT_Z:   prdata = APB_DW'(cfg_q.extent[2]);
      REG_EXTENT_T:   prdata = APB_DW'(cfg_q.extent[3]);
      REG_LOCAL_COMM: prdata = APB_DW'(cfg_q.local_mask);
      default:        prdata = '0;
    endcase
  end

  assign coord = {coord_t_i, coord_z_i, coord_y_i, coord_x_i};

  lnag_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .push_i    (push),
    .coord_i   (coord),
    .sense_i   (shift_sense_i),
    .full_o    (full),
    .q_wr_o    (q_wr),
    .q_wdata_o (q_wdata),
    .q_full_i  (q_full)
  );

  lnag_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  lnag_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_rdata_i (q_rdata),
    .q_rd_o    (q_rd),
    .empty_o   (empty),
    .pop_i     (pop),
    .res_o     (res)
  );

  assign direction_o      = res.direction;
  assign site_parity_o    = res.site_parity;
  assign table_sense_o    = res.table_sense;
  assign table_index_o    = res.table_index;
  assign target_buffer_o  = res.target_buffer;
  assign element_offset_o = res.element_offset;
  assign face_write_o     = res.face_write;
  assign face_sense_o     = res.face_sense;
  assign face_slot_o      = res.face_slot;
  assign last_o           = res.last;

endmodule

`default_nettype wire
